/* rtl/line_rasterizer_core_assert.svh */
// Assertion macros for the line rasterizer core.
`ifndef LINE_RASTERIZER_CORE_ASSERT_SVH
`define LINE_RASTERIZER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LRC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line rasterizer: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define LRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line rasterizer: next-cycle check failed");
`else
`define LRC_ASSERT_IMP(label, clk, rst, ante, cons)
`define LRC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/lrc_pkg.sv */
// Shared types and constants of the line rasterizer core.
`timescale 1ns / 1ps
package lrc_pkg;

   // Port field width and the number of coordinate bits actually used
   localparam int FieldBits = 6;
   localparam int CoordBits = 6;
   // Error term: signed, headroom for twice the largest delta plus sign
   localparam int ErrBits   = CoordBits + 4;

   typedef enum logic [0:0] {
      LRC_IDLE,
      LRC_WALK
   } lrc_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic emit;
   } lrc_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic slot_free;
      logic at_last;
   } lrc_status_type;

endpackage

/* rtl/lrc_ctrl.sv */
// Controller state machine: takes a line, then walks it one pixel a cycle while the output register can take the pixel.
`timescale 1ns / 1ps
module lrc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  lrc_pkg::lrc_status_type status,
   output lrc_pkg::lrc_cmd_type    cmd
);

   lrc_pkg::lrc_state_type state_ff;
   lrc_pkg::lrc_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrc_pkg::LRC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         lrc_pkg::LRC_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = lrc_pkg::LRC_WALK;
            end
         end
         lrc_pkg::LRC_WALK: begin
            // advance only when the output register can take the pixel
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               if (status.at_last) begin
                  state_in = lrc_pkg::LRC_IDLE;
               end
            end
         end
         default: begin
            state_in = lrc_pkg::LRC_IDLE;
         end
      endcase
   end

endmodule

/* rtl/lrc_datapath.sv */
// Datapath: endpoint setup, Bresenham stepping and the output register.
`timescale 1ns / 1ps
`include "line_rasterizer_core_assert.svh"
module lrc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lrc_pkg::lrc_cmd_type                cmd,
   output lrc_pkg::lrc_status_type             status,
   input  logic [lrc_pkg::FieldBits-1:0]       req_x_start,
   input  logic [lrc_pkg::FieldBits-1:0]       req_y_start,
   input  logic [lrc_pkg::FieldBits-1:0]       req_x_end,
   input  logic [lrc_pkg::FieldBits-1:0]       req_y_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lrc_pkg::FieldBits-1:0]       rsp_pixel_x,
   output logic [lrc_pkg::FieldBits-1:0]       rsp_pixel_y,
   output logic                                rsp_last_pixel
);

   localparam int CB = lrc_pkg::CoordBits;
   localparam int EB = lrc_pkg::ErrBits;

   // Masked endpoints
   logic [CB-1:0] xa, ya, xb, yb;
   logic [CB-1:0] adx, ady;
   logic          shallow;
   logic [CB-1:0] maj_lo, maj_hi, min_lo, min_hi;
   logic [CB-1:0] dmaj, dmin;
   logic          neg;
   logic signed [EB-1:0] err_init;

   // Walk state
   logic [CB-1:0]        major_ff, major_in;
   logic [CB-1:0]        minor_ff, minor_in;
   logic [CB-1:0]        major_hi_ff;
   logic [CB-1:0]        dmaj_ff, dmin_ff;
   logic                 neg_ff, shallow_ff;
   logic signed [EB-1:0] err_ff, err_in;
   logic                 err_pos;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]        rsp_x_ff, rsp_y_ff;
   logic                 rsp_last_ff;

   // Set up the line: pick the major axis and order the endpoints
   always_comb begin
      xa = req_x_start[CB-1:0];
      ya = req_y_start[CB-1:0];
      xb = req_x_end[CB-1:0];
      yb = req_y_end[CB-1:0];
      adx = (xb > xa) ? (xb - xa) : (xa - xb);
      ady = (yb > ya) ? (yb - ya) : (ya - yb);
      shallow = (ady < adx);
      if (shallow) begin
         if (xa > xb) begin
            maj_lo = xb; min_lo = yb; maj_hi = xa; min_hi = ya;
         end else begin
            maj_lo = xa; min_lo = ya; maj_hi = xb; min_hi = yb;
         end
      end else begin
         if (ya > yb) begin
            maj_lo = yb; min_lo = xb; maj_hi = ya; min_hi = xa;
         end else begin
            maj_lo = ya; min_lo = xa; maj_hi = yb; min_hi = xb;
         end
      end
      dmaj = maj_hi - maj_lo;
      neg  = (min_hi < min_lo);
      dmin = neg ? (min_lo - min_hi) : (min_hi - min_lo);
      err_init = $signed(EB'({dmin, 1'b0})) - $signed(EB'(dmaj));
   end

   // Step the minor axis when the error term is strictly positive
   always_comb begin
      err_pos  = !err_ff[EB-1] && (err_ff != '0);
      major_in = major_ff + CB'(1);
      minor_in = minor_ff;
      err_in   = err_ff + $signed(EB'({dmin_ff, 1'b0}));
      if (err_pos) begin
         minor_in = neg_ff ? (minor_ff - CB'(1)) : (minor_ff + CB'(1));
         err_in   = err_ff + $signed(EB'({dmin_ff, 1'b0}))
                           - $signed(EB'({dmaj_ff, 1'b0}));
      end
   end

   // Load a new line or advance one pixel
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         major_ff    <= maj_lo;
         minor_ff    <= min_lo;
         major_hi_ff <= maj_hi;
         dmaj_ff     <= dmaj;
         dmin_ff     <= dmin;
         neg_ff      <= neg;
         shallow_ff  <= shallow;
         err_ff      <= err_init;
      end else if (cmd.emit) begin
         major_ff <= major_in;
         minor_ff <= minor_in;
         err_ff   <= err_in;
      end
   end

   // Output register: fill on emit, drop after the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_x_ff    <= shallow_ff ? major_ff : minor_ff;
         rsp_y_ff    <= shallow_ff ? minor_ff : major_ff;
         rsp_last_ff <= (major_ff == major_hi_ff);
      end
   end

   assign status.slot_free = !rsp_valid_ff || !rsp_stall;
   assign status.at_last   = (major_ff == major_hi_ff);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = lrc_pkg::FieldBits'(rsp_x_ff);
   assign rsp_pixel_y    = lrc_pkg::FieldBits'(rsp_y_ff);
   assign rsp_last_pixel = rsp_last_ff;

   // A pixel is never pushed over one still waiting for its transfer
   `LRC_ASSERT_IMP(a_emit_free, clock, reset, cmd.emit, !rsp_valid_ff || !rsp_stall)
   // Each non-final pixel advances the major axis by one
   `LRC_ASSERT_NEXT(a_major_step, clock, reset, cmd.emit && !status.at_last && !cmd.load, major_ff == $past(major_ff) + CB'(1))
   // A loaded line starts at or below its end on the major axis
   `LRC_ASSERT_NEXT(a_load_order, clock, reset, cmd.load, major_ff <= major_hi_ff)

endmodule

/* rtl/line_rasterizer_core.sv */
// Top level of the line rasterizer core: controller plus datapath.
`timescale 1ns / 1ps
// Usage:
//   The req_ channel takes one line as two endpoints (x_start, y_start,
//   x_end, y_end). A transfer happens at a clock edge with req_valid high
//   and req_stall low. The rsp_ channel returns one pixel per transfer,
//   ordered along the increasing major axis, with rsp_last_pixel high on
//   the final pixel of the line.
//   First pixel: setup is combinational in the transfer cycle, which loads
//   the walk registers; the first stepping cycle then fills the output
//   register, which presents the pixel.
//   Throughput: a line of N pixels (1 to 64) is taken, then the stepping
//   loop yields one pixel per cycle while the receiver does not stall.
//   A new line is taken as soon as its final pixel sits in the output
//   register.
//   Stall: while rsp_stall is high with a pixel waiting, the output register
//   holds it and the loop waits; req_stall stays high for the whole walk.
//   Reset (synchronous, active high) returns to idle and drops any pixel
//   waiting in the output register; the next line may follow at once.
module line_rasterizer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lrc_pkg::FieldBits-1:0] req_x_start,
   input  logic [lrc_pkg::FieldBits-1:0] req_y_start,
   input  logic [lrc_pkg::FieldBits-1:0] req_x_end,
   input  logic [lrc_pkg::FieldBits-1:0] req_y_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lrc_pkg::FieldBits-1:0] rsp_pixel_x,
   output logic [lrc_pkg::FieldBits-1:0] rsp_pixel_y,
   output logic                          rsp_last_pixel
);

   lrc_pkg::lrc_cmd_type    cmd;
   lrc_pkg::lrc_status_type status;

   // Sequence the walk
   lrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Set up, step and register the pixels
   lrc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule
